FILE: src/clpw_pkg.sv
`default_nettype none
package clpw_pkg;
	typedef enum logic [2:0] {
		ACT_TICK = 3'd0,
		ACT_CMD  = 3'd1,
		ACT_LOAD = 3'd2,
		ACT_STR  = 3'd3,
		ACT_NUM  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		JOB_IDLE = 3'd0,
		JOB_INIT = 3'd1,
		JOB_CMD  = 3'd2,
		JOB_STR  = 3'd3,
		JOB_NUM  = 3'd4
	} job_t;

	typedef enum logic [2:0] {
		REG_FSET  = 3'd0,
		REG_DCTL  = 3'd1,
		REG_EMODE = 3'd2,
		REG_LINE1 = 3'd3,
		REG_LINE2 = 3'd4,
		REG_LASTC = 3'd5
	} reg_index_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_NO_INIT = 2'd2;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_DDRAM  = 8'h80;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam int MaxDigits = 10;
endpackage
`default_nettype wire

FILE: src/clpw_ram.sv
`default_nettype none
module clpw_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: src/clpw_digits.sv
`default_nettype none
// Splits a 32-bit value into decimal digits, least significant first, one digit per pass
// through the multiply and digit states, using a reciprocal multiply split into two 16x32 halves.
module clpw_digits
	import clpw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] value,
	output logic             busy,
	output logic             dig_we,
	output logic [3:0]       dig_addr,
	output logic [3:0]       dig_data,
	output logic [3:0]       count
);
	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIG} state_t;
	state_t      state_q;
	logic [31:0] num_q;
	logic [3:0]  n_q;
	logic [48:0] plo_q, phi_q;
	logic [64:0] prod;
	logic [31:0] quo;
	logic [35:0] q10;
	logic [3:0]  rem;
	localparam logic [32:0] Recip = 33'h0CCCCCCCD; // ceil(2^35/10)

	assign prod = {16'd0, plo_q} + {phi_q, 16'd0};
	assign quo  = {2'd0, prod[64:35]};
	assign q10  = {1'd0, quo, 3'd0} + {3'd0, quo, 1'd0};
	assign rem  = 4'(num_q - q10[31:0]);
	assign busy = (state_q != S_IDLE) || start;
	assign dig_data = (num_q == 32'd0) ? 4'd0 : rem;
	assign dig_addr = n_q;
	assign dig_we = (state_q == S_DIG);
	assign count = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					num_q <= value;
					n_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					plo_q <= {33'd0, num_q[15:0]} * {16'd0, Recip};
					phi_q <= {33'd0, num_q[31:16]} * {16'd0, Recip};
					state_q <= S_DIG;
				end
				S_DIG: begin
					n_q <= n_q + 4'd1;
					if (num_q == 32'd0 || quo == 32'd0) begin
						state_q <= S_IDLE;
					end else begin
						num_q <= quo;
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/char_lcd_parallel_write_sequencer_top.sv
`default_nettype none
// A tick or request is answered in the cycle after its transfer, from an output register,
// and the next item can be taken on that same edge, so one item per cycle while the output
// is not stalled. A tick that drives a stored character or digit first passes through a read
// state for the synchronous RAM read, and a number request holds the input in the number
// state while the digit unit emits its digits.
// Reset starts the init sequence with all pins low; buffer contents are undefined.
module char_lcd_parallel_write_sequencer_top
	import clpw_pkg::*;
#(
	parameter int TEXT_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  byte_value,
	input  wire logic [4:0]  char_slot,
	input  wire logic [5:0]  char_count,
	input  wire logic [6:0]  column,
	input  wire logic [6:0]  row_address,
	input  wire logic [31:0] number_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             reg_select,
	output logic             read_write,
	output logic             enable,
	output logic [7:0]       data_bus,
	output logic             busy_res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	localparam int TAw = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int TDp = (TEXT_DEPTH > 1) ? TEXT_DEPTH : 2;
	localparam int LenW = $clog2(TEXT_DEPTH + 1);

	typedef enum logic [1:0] {E_IDLE, E_READ, E_NUM} est_t;
	est_t state_q;

	logic [7:0] fset_q, dctl_q, emode_q;
	logic [6:0] line1_q, line2_q;
	logic [5:0] lastc_q;
	logic [3:0] phase_q;
	job_t job_q;
	logic [1:0] init_step_q;
	logic init_done_q, addr_pend_q;
	logic [7:0] cmd_hold_q, addr_byte_q;
	logic [LenW-1:0] tlen_q, tpos_q;
	logic [3:0] dtot_q, dpos_q;
	logic rs_q, en_q;
	logic [7:0] bus_q;

	logic tram_we;
	logic [TAw-1:0] tram_raddr;
	logic [7:0] tram_rdata;
	logic [3:0] dram_raddr, dram_rdata, dram_waddr, dram_wdata, dig_count;
	logic dram_we, dig_busy, dig_start;

	assign in_ready = (state_q == E_IDLE) && (!out_valid || out_ready);
	assign read_write = 1'b0;
	wire accept = in_valid && in_ready;

	assign tram_we = accept && action == ACT_LOAD && init_done_q && job_q == JOB_IDLE
		&& (int'(char_slot) < TEXT_DEPTH);
	assign tram_raddr = TAw'(tpos_q);
	assign dram_raddr = 4'(dtot_q - 4'd1 - dpos_q);

	clpw_ram #(.Width(8), .Depth(TDp)) u_text (
		.clk(clk), .we(tram_we), .waddr(TAw'(char_slot)), .wdata(byte_value),
		.raddr(tram_raddr), .rdata(tram_rdata));
	clpw_ram #(.Width(4), .Depth(16)) u_dig (
		.clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
		.raddr(dram_raddr), .rdata(dram_rdata));

	assign dig_start = accept && action == ACT_NUM && init_done_q && job_q == JOB_IDLE;
	clpw_digits u_digits (
		.clk(clk), .arst_n(arst_n), .start(dig_start), .value(number_value),
		.busy(dig_busy), .dig_we(dram_we), .dig_addr(dram_waddr),
		.dig_data(dram_wdata), .count(dig_count));

	// Bytes from the RAMs are only needed at the bus-drive phase of data bytes.
	wire need_ram = accept && action == ACT_TICK && phase_q == 4'd3 && !addr_pend_q
		&& (job_q == JOB_STR || job_q == JOB_NUM);

	logic [7:0] cur_byte;
	always_comb begin
		unique case (job_q)
			JOB_INIT: begin
				unique case (init_step_q)
					2'd0: cur_byte = fset_q;
					2'd1: cur_byte = CMD_CLEAR;
					2'd2: cur_byte = dctl_q;
					default: cur_byte = emode_q;
				endcase
			end
			JOB_CMD: cur_byte = cmd_hold_q;
			JOB_STR: cur_byte = addr_pend_q ? addr_byte_q : tram_rdata;
			JOB_NUM: cur_byte = addr_pend_q ? addr_byte_q : (ASCII_ZERO | {4'd0, dram_rdata});
			default: cur_byte = 8'd0;
		endcase
	end

	logic pos_ok;
	logic [6:0] pos_base;
	always_comb begin
		pos_ok = 1'b0;
		pos_base = line1_q;
		if ({1'b0, column} <= {2'b0, lastc_q}) begin
			if (row_address == line1_q) begin
				pos_ok = 1'b1;
			end else if (row_address == line2_q) begin
				pos_ok = 1'b1;
				pos_base = line2_q;
			end
		end
	end

	logic [LenW-1:0] sat_len;
	assign sat_len = (int'(char_count) > TEXT_DEPTH) ? LenW'(TEXT_DEPTH)
		: LenW'(char_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			fset_q <= 8'h38; dctl_q <= 8'h0C; emode_q <= 8'h06;
			line1_q <= 7'd0; line2_q <= 7'd64; lastc_q <= 6'd15;
			phase_q <= '0; job_q <= JOB_INIT; init_step_q <= '0; init_done_q <= 1'b0;
			addr_pend_q <= 1'b0; cmd_hold_q <= '0; addr_byte_q <= '0;
			tlen_q <= '0; tpos_q <= '0; dtot_q <= '0; dpos_q <= '0;
			rs_q <= 1'b0; en_q <= 1'b0; bus_q <= '0;
			out_valid <= 1'b0; status <= ST_OK; reg_select <= 1'b0;
			enable <= 1'b0; data_bus <= '0; busy_res <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FSET:  fset_q <= cfg_data;
					REG_DCTL:  dctl_q <= cfg_data;
					REG_EMODE: emode_q <= cfg_data;
					REG_LINE1: line1_q <= cfg_data[6:0];
					REG_LINE2: line2_q <= cfg_data[6:0];
					REG_LASTC: lastc_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				E_IDLE: if (accept) begin
					status <= ST_OK;
					if (need_ram) begin
						state_q <= E_READ;
					end else if (action == ACT_TICK) begin
						if (job_q != JOB_IDLE) begin
							unique case (phase_q)
								4'd0: rs_q <= (job_q == JOB_STR || job_q == JOB_NUM)
									&& !addr_pend_q;
								4'd2: en_q <= 1'b1;
								4'd3: bus_q <= cur_byte;
								4'd4: en_q <= 1'b0;
								default: ;
							endcase
							if (phase_q >= 4'd5) begin
								phase_q <= '0;
								unique case (job_q)
									JOB_INIT: begin
										init_step_q <= init_step_q + 2'd1;
										if (init_step_q == 2'd3) begin
											init_done_q <= 1'b1;
											job_q <= JOB_IDLE;
										end
									end
									JOB_STR: begin
										if (addr_pend_q) begin
											addr_pend_q <= 1'b0;
											if (tpos_q >= tlen_q) job_q <= JOB_IDLE;
										end else begin
											tpos_q <= tpos_q + 1'b1;
											if (tpos_q + 1'b1 >= tlen_q) job_q <= JOB_IDLE;
										end
									end
									JOB_NUM: begin
										if (addr_pend_q) begin
											addr_pend_q <= 1'b0;
											if (dpos_q >= dtot_q) job_q <= JOB_IDLE;
										end else begin
											dpos_q <= dpos_q + 4'd1;
											if (dpos_q + 4'd1 >= dtot_q) job_q <= JOB_IDLE;
										end
									end
									default: job_q <= JOB_IDLE;
								endcase
							end else begin
								phase_q <= phase_q + 4'd1;
							end
						end
					end else if (action <= ACT_NUM) begin
						if (!init_done_q) begin
							status <= ST_NO_INIT;
						end else if (job_q != JOB_IDLE) begin
							status <= ST_BUSY;
						end else begin
							priority case (action)
								ACT_CMD: begin
									cmd_hold_q <= byte_value;
									phase_q <= '0;
									job_q <= JOB_CMD;
								end
								ACT_STR: begin
									tlen_q <= sat_len;
									tpos_q <= '0;
									addr_pend_q <= pos_ok;
									addr_byte_q <= CMD_DDRAM | {1'b0, 7'(pos_base + column)};
									phase_q <= '0;
									job_q <= (pos_ok || sat_len != '0) ? JOB_STR : JOB_IDLE;
								end
								ACT_NUM: begin
									dpos_q <= '0;
									addr_pend_q <= pos_ok;
									addr_byte_q <= CMD_DDRAM | {1'b0, 7'(pos_base + column)};
									phase_q <= '0;
									job_q <= JOB_NUM;
									state_q <= E_NUM;
								end
								default: ;
							endcase
						end
					end
					if (!(need_ram || dig_start)) begin
						out_valid <= 1'b1;
						reg_select <= rs_q; enable <= en_q; data_bus <= bus_q;
						busy_res <= (job_q != JOB_IDLE);
						if (action == ACT_TICK) begin
							if (job_q != JOB_IDLE) begin
								if (phase_q == 4'd0)
									reg_select <= (job_q == JOB_STR || job_q == JOB_NUM)
										&& !addr_pend_q;
								if (phase_q == 4'd2) enable <= 1'b1;
								if (phase_q == 4'd3) data_bus <= cur_byte;
								if (phase_q == 4'd4) enable <= 1'b0;
								if (phase_q >= 4'd5) begin
									unique case (job_q)
										JOB_INIT: busy_res <= (init_step_q != 2'd3);
										JOB_STR: busy_res <= addr_pend_q ? (tpos_q < tlen_q)
											: (tpos_q + 1'b1 < tlen_q);
										JOB_NUM: busy_res <= addr_pend_q ? (dpos_q < dtot_q)
											: (dpos_q + 4'd1 < dtot_q);
										default: busy_res <= 1'b0;
									endcase
								end
							end
						end else if (action <= ACT_NUM && init_done_q && job_q == JOB_IDLE) begin
							if (action == ACT_CMD) busy_res <= 1'b1;
							if (action == ACT_STR) busy_res <= pos_ok || sat_len != '0;
						end
					end
				end
				E_READ: begin
					// RAM data is valid now; the drive phase completes.
					bus_q <= cur_byte;
					phase_q <= phase_q + 4'd1;
					out_valid <= 1'b1;
					reg_select <= rs_q; enable <= en_q; data_bus <= cur_byte;
					busy_res <= 1'b1;
					state_q <= E_IDLE;
				end
				E_NUM: if (!dig_busy) begin
					dtot_q <= dig_count;
					out_valid <= 1'b1;
					reg_select <= rs_q; enable <= en_q; data_bus <= bus_q;
					busy_res <= 1'b1;
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
